[hw/rtl/stlb_pkg.sv]
// Shared types and constants for the scrolling text line buffer.
// No dependencies; compiled first.
package stlb_pkg;

    localparam int CHAR_W = 8;
    localparam int ROW_W  = 4;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

    typedef enum logic {
        CMD_RECEIVE = 1'b0,
        CMD_RENDER  = 1'b1
    } t_cmd;

    // One classified command as it sits in the queue between front and back.
    // row is already reduced modulo the line count (always below 16).
    typedef struct packed {
        logic              is_render;
        logic              is_newline;
        logic [CHAR_W-1:0] data;
        logic [ROW_W-1:0]  row;
    } t_op;

endpackage

[hw/rtl/stlb_if.sv]
// Valid/ready channel interfaces for the command input and the character output.
// Depends on stlb_pkg.
interface stlb_in_if;
    import stlb_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAR_W-1:0] char_in;
    logic [ROW_W-1:0]  row;

    modport source (output valid, command, char_in, row, input ready);
    modport sink   (input valid, command, char_in, row, output ready);
endinterface

interface stlb_out_if #(
    parameter int COL_W = 5
);
    import stlb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic [COL_W-1:0]  column;
    logic              last;

    modport source (output valid, char_out, column, last, input ready);
    modport sink   (input valid, char_out, column, last, output ready);
endinterface

[hw/rtl/scrolling_text_line_buffer_top.sv]
// Top level of the scrolling text line buffer: command front end, queue and back end.
// Depends on stlb_pkg, stlb_if, stlb_front and stlb_back.

// A ring of LINE_COUNT text lines, LINE_WIDTH bytes each, for a small text
// terminal. A receive transaction (command 0) stores char_in at the current
// column of the head line and puts a newline after it; a newline byte moves the
// head to the next line and pushes the tail when the ring is full. A render
// transaction (command 1) reads visible row (tail + row) mod LINE_COUNT and
// returns LINE_WIDTH output transactions, one per column, with spaces from the
// first newline onward and last set on the final column. Timing: the front end
// queues up to two commands; the back end handles a receive as dequeue, newline
// mark and byte store (the line store has a single write port) and a render
// with one store read per column. Characters leave through an output register
// at up to one per cycle; a stalled output holds the read pipeline without
// losing data.
// No clearing pass after reset: one flag per line stands in for the newline
// in column 0 until that column is first written.
module scrolling_text_line_buffer_top #(
    parameter int LINE_COUNT = 17,
    parameter int LINE_WIDTH = 22
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stlb_in_if.sink     i_cmd,
    stlb_out_if.source  o_res
);
    import stlb_pkg::*;

    // queue handoff between front and back
    logic w_q_valid;
    t_op  w_q_op;
    logic w_q_pop;

    stlb_front #(
        .LINE_COUNT (LINE_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (w_q_valid),
        .o_q_op    (w_q_op),
        .i_q_pop   (w_q_pop)
    );

    stlb_back #(
        .LINE_COUNT (LINE_COUNT),
        .LINE_WIDTH (LINE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_op    (w_q_op),
        .o_q_pop   (w_q_pop),
        .o_res     (o_res)
    );

endmodule

[hw/rtl/stlb_front.sv]
// Front end: accepts command transactions, classifies them and queues them.
// Depends on stlb_pkg and stlb_in_if.
module stlb_front #(
    parameter int LINE_COUNT = 17
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stlb_in_if.sink        i_cmd,
    output logic           o_q_valid,
    output stlb_pkg::t_op  o_q_op,
    input  logic           i_q_pop
);
    import stlb_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int ROWS   = 2 ** ROW_W;

    t_op               r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic [ROW_W-1:0]  w_row_mod [ROWS];
    logic              w_push;
    t_op               w_op;

    // row mod LINE_COUNT, fixed at elaboration
    for (genvar g = 0; g < ROWS; g++) begin : g_row_mod
        assign w_row_mod[g] = ROW_W'(g % LINE_COUNT);
    end

    assign i_cmd.ready = (r_count != QCNT_W'(QDEPTH));
    assign w_push      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        w_op.is_render  = (i_cmd.command == CMD_RENDER);
        w_op.is_newline = (i_cmd.char_in == NEWLINE_CHAR);
        w_op.data       = i_cmd.char_in;
        w_op.row        = w_row_mod[i_cmd.row];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({w_push, i_q_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_op    = r_q[r_rptr];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count overflow");

endmodule

[hw/rtl/stlb_back.sv]
// Back end: line store, head/tail/column state, receive writes and row rendering.
// Depends on stlb_pkg and stlb_out_if.
module stlb_back #(
    parameter int LINE_COUNT = 17,
    parameter int LINE_WIDTH = 22
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  stlb_pkg::t_op  i_q_op,
    output logic           o_q_pop,
    stlb_out_if.source     o_res
);
    import stlb_pkg::*;

    localparam int LINE_W = $clog2(LINE_COUNT);
    localparam int COLC_W = $clog2(LINE_WIDTH + 1);
    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int DEPTH  = LINE_COUNT * LINE_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ((LINE_W > ROW_W) ? LINE_W : ROW_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RX_MARK,
        S_RX_STORE,
        S_RENDER
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [LINE_W-1:0]   r_head;
    logic [LINE_W-1:0]   r_tail;
    logic [COLC_W-1:0]   r_wcol;
    logic [LINE_W-1:0]   r_line;
    logic [COL_W-1:0]    r_rcol;
    logic [LINE_COUNT-1:0] r_col0_ok;

    logic [CHAR_W-1:0]   r_mem [DEPTH];
    logic [CHAR_W-1:0]   r_rd;
    logic                r_s1_valid;
    logic [COL_W-1:0]    r_s1_col;
    logic                r_s1_force_nl;

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic [COL_W-1:0]    r_out_col;
    logic                r_out_last;
    logic                r_ended;

    logic [SUM_W-1:0]    w_sum;
    logic [LINE_W-1:0]   w_line;
    logic [LINE_W-1:0]   w_head_nx;
    logic [LINE_W-1:0]   w_tail_nx;
    logic                w_issue;
    logic                w_s1_move;
    logic                w_end;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [CHAR_W-1:0]   w_wdata;
    logic [ADDR_W-1:0]   w_raddr;
    logic [COLC_W:0]     w_wcol_p1;
    logic [ADDR_W-1:0]   w_head_base;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // line = (tail + row) mod LINE_COUNT; row already below LINE_COUNT
    assign w_sum  = SUM_W'(r_tail) + SUM_W'(i_q_op.row);
    assign w_line = (w_sum >= SUM_W'(LINE_COUNT)) ? LINE_W'(w_sum - SUM_W'(LINE_COUNT))
                                                  : LINE_W'(w_sum);

    assign w_head_nx = (r_head == LINE_W'(LINE_COUNT - 1)) ? '0 : r_head + LINE_W'(1);
    assign w_tail_nx = (r_tail == LINE_W'(LINE_COUNT - 1)) ? '0 : r_tail + LINE_W'(1);

    assign w_s1_move = r_s1_valid && (!r_out_valid || o_res.ready);
    assign w_issue   = (r_state == S_RENDER) && (!r_s1_valid || w_s1_move);

    assign w_wcol_p1   = {1'b0, r_wcol} + (COLC_W + 1)'(1);
    assign w_head_base = ADDR_W'(r_head) * ADDR_W'(LINE_WIDTH);
    assign w_raddr     = ADDR_W'(r_line) * ADDR_W'(LINE_WIDTH) + ADDR_W'(r_rcol);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_head_base + ADDR_W'(r_wcol);
        w_wdata = r_op.data;
        case (r_state)
            S_RX_MARK: begin
                w_we    = (w_wcol_p1 < (COLC_W + 1)'(LINE_WIDTH));
                w_waddr = w_head_base + ADDR_W'(w_wcol_p1);
                w_wdata = NEWLINE_CHAR;
            end
            S_RX_STORE: begin
                w_we    = (r_wcol < COLC_W'(LINE_WIDTH));
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    // end of text once a newline is seen; column 0 of a never-written line is a newline
    assign w_end = ((r_s1_col != '0) && r_ended) || r_s1_force_nl || (r_rd == NEWLINE_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_wcol      <= '0;
            r_col0_ok   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op   <= i_q_op;
                        r_line <= w_line;
                        r_rcol <= '0;
                        r_state <= i_q_op.is_render ? S_RENDER : S_RX_MARK;
                    end
                end
                S_RX_MARK: begin
                    r_state <= S_RX_STORE;
                end
                S_RX_STORE: begin
                    if (r_op.is_newline) begin
                        r_head <= w_head_nx;
                        r_wcol <= '0;
                        if (w_head_nx == r_tail) begin
                            r_tail <= w_tail_nx;
                        end
                    end else if (r_wcol < COLC_W'(LINE_WIDTH)) begin
                        r_wcol <= r_wcol + COLC_W'(1);
                    end
                    if (r_wcol == '0) begin
                        r_col0_ok[r_head] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_RENDER: begin
                    if (w_issue) begin
                        r_rcol <= r_rcol + COL_W'(1);
                        if (r_rcol == COL_W'(LINE_WIDTH - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_issue) begin
                r_s1_valid    <= 1'b1;
                r_s1_col      <= r_rcol;
                r_s1_force_nl <= (r_rcol == '0) && !r_col0_ok[r_line];
            end else if (w_s1_move) begin
                r_s1_valid    <= 1'b0;
            end

            if (w_s1_move) begin
                r_out_valid <= 1'b1;
                r_out_char  <= w_end ? SPACE_CHAR : r_rd;
                r_out_col   <= r_s1_col;
                r_out_last  <= (r_s1_col == COL_W'(LINE_WIDTH - 1));
                r_ended     <= w_end;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.char_out = r_out_char;
    assign o_res.column   = r_out_col;
    assign o_res.last     = r_out_last;

    a_wcol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcol <= COLC_W'(LINE_WIDTH))
        else $error("write column past line end");

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < LINE_W'(LINE_COUNT)) && (r_tail < LINE_W'(LINE_COUNT)))
        else $error("head or tail outside ring");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_move |=> r_s1_valid && $stable(r_s1_col))
        else $error("read stage lost data under stall");

endmodule
